// ===== hw/rtl/tcpop_pkg.sv =====
// Package with the transaction types and option codes of the TCP option parser.
`default_nettype none

package tcpop_pkg;

   localparam int MAX_AREA_BYTES_DEFAULT = 40;

   localparam logic [7:0] KIND_EOL     = 8'd0;
   localparam logic [7:0] KIND_NOP     = 8'd1;
   localparam logic [7:0] KIND_MSS     = 8'd2;
   localparam logic [7:0] KIND_SCALE   = 8'd3;
   localparam logic [7:0] KIND_SACK_OK = 8'd4;
   localparam logic [7:0] KIND_SACK    = 8'd5;
   localparam logic [7:0] KIND_STAMP   = 8'd8;

   localparam logic [7:0] HDR_BYTES    = 8'd2;
   localparam logic [7:0] LEN_MSS      = 8'd4;
   localparam logic [7:0] LEN_SCALE    = 8'd3;
   localparam logic [7:0] LEN_SACK_OK  = 8'd2;
   localparam logic [7:0] LEN_STAMP    = 8'd10;

   localparam logic [7:0] SCALE_LIMIT  = 8'd14;

   localparam int FLAG_MSS     = 0;
   localparam int FLAG_SCALE   = 1;
   localparam int FLAG_STAMP   = 2;
   localparam int FLAG_SACK_OK = 3;
   localparam int FLAG_SACK    = 4;
   localparam int FLAG_COUNT   = 5;

   typedef struct packed {
      logic [7:0] option_byte;
      logic       area_start;
      logic [5:0] area_length;
   } req_type;

   typedef struct packed {
      logic        mss_present;
      logic [15:0] mss_value;
      logic        scale_present;
      logic [3:0]  scale_shift;
      logic        stamp_present;
      logic [31:0] stamp_value;
      logic [31:0] stamp_echo;
      logic        sack_allowed;
      logic        sack_present;
      logic [2:0]  sack_blocks;
      logic [5:0]  sack_offset;
   } rsp_type;

endpackage

`default_nettype wire

// ===== hw/rtl/tcpop_parse.sv =====
// Option walker: parse state registers and the per-byte next-state and record logic.
`default_nettype none

module tcpop_parse
   import tcpop_pkg::*;
#(
   parameter int MAX_AREA_BYTES = MAX_AREA_BYTES_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    enable,
   input  wire req_type req,
   output logic         emit,
   output rsp_type      result
);

   localparam logic [5:0] AREA_MAX = 6'(MAX_AREA_BYTES);

   logic [5:0]            bytes_left_ff, bytes_left_in;
   logic [5:0]            byte_position_ff, byte_position_in;
   logic                  parse_stopped_ff, parse_stopped_in;
   logic [7:0]            current_kind_ff, current_kind_in;
   logic [7:0]            current_length_ff, current_length_in;
   logic [5:0]            index_in_option_ff, index_in_option_in;
   logic                  current_valid_ff, current_valid_in;
   logic [FLAG_COUNT-1:0] found_flags_ff, found_flags_in;
   logic [15:0]           mss_store_ff, mss_store_in;
   logic [3:0]            scale_store_ff, scale_store_in;
   logic [31:0]           stamp_value_store_ff, stamp_value_store_in;
   logic [31:0]           stamp_echo_store_ff, stamp_echo_store_in;
   logic [2:0]            sack_count_store_ff, sack_count_store_in;
   logic [5:0]            sack_offset_store_ff, sack_offset_store_in;

   logic                  active;
   logic [5:0]            start_len;
   logic [5:0]            left_now;
   logic [5:0]            pos_now;
   logic                  stopped_now;
   logic [5:0]            index_now;
   logic                  valid_now;
   logic [FLAG_COUNT-1:0] flags_now;
   logic [7:0]            b;
   logic [7:0]            len_minus_hdr;
   logic [5:0]            data_index;
   logic [5:0]            index_step;
   logic [4:0]            stamp_shift;

   always_comb begin
      b = req.option_byte;
      active = req.area_start || (bytes_left_ff != 6'd0);

      start_len = req.area_length;
      if (start_len == 6'd0) begin
         start_len = 6'd1;
      end else if (start_len > AREA_MAX) begin
         start_len = AREA_MAX;
      end

      if (req.area_start) begin
         left_now    = start_len;
         pos_now     = 6'd0;
         stopped_now = 1'b0;
         index_now   = 6'd0;
         valid_now   = 1'b0;
         flags_now   = '0;
      end else begin
         left_now    = bytes_left_ff;
         pos_now     = byte_position_ff;
         stopped_now = parse_stopped_ff;
         index_now   = index_in_option_ff;
         valid_now   = current_valid_ff;
         flags_now   = found_flags_ff;
      end

      bytes_left_in        = bytes_left_ff;
      byte_position_in     = byte_position_ff;
      parse_stopped_in     = parse_stopped_ff;
      current_kind_in      = current_kind_ff;
      current_length_in    = current_length_ff;
      index_in_option_in   = index_in_option_ff;
      current_valid_in     = current_valid_ff;
      found_flags_in       = found_flags_ff;
      mss_store_in         = mss_store_ff;
      scale_store_in       = scale_store_ff;
      stamp_value_store_in = stamp_value_store_ff;
      stamp_echo_store_in  = stamp_echo_store_ff;
      sack_count_store_in  = sack_count_store_ff;
      sack_offset_store_in = sack_offset_store_ff;

      len_minus_hdr = b - HDR_BYTES;
      data_index    = index_now - 6'(HDR_BYTES);
      index_step    = index_now + 6'd1;
      stamp_shift   = {2'd3 - data_index[1:0], 3'd0};

      if (active) begin
         parse_stopped_in   = stopped_now;
         index_in_option_in = index_now;
         current_valid_in   = valid_now;
         found_flags_in     = flags_now;

         if (!stopped_now) begin
            if (index_now == 6'd0) begin
               if (b == KIND_EOL) begin
                  parse_stopped_in = 1'b1;
               end else if (b != KIND_NOP) begin
                  if (left_now < 6'(HDR_BYTES)) begin
                     parse_stopped_in = 1'b1;
                  end else begin
                     current_kind_in    = b;
                     index_in_option_in = 6'd1;
                  end
               end
            end else if (index_now == 6'd1) begin
               if (b < HDR_BYTES || b > ({2'd0, left_now} + 8'd1)) begin
                  parse_stopped_in = 1'b1;
               end else begin
                  current_length_in  = b;
                  current_valid_in   = 1'b0;
                  index_in_option_in = (b == HDR_BYTES) ? 6'd0 : 6'd2;
                  case (current_kind_ff)
                     KIND_MSS: begin
                        current_valid_in = (b == LEN_MSS);
                        if (b == LEN_MSS) found_flags_in[FLAG_MSS] = 1'b1;
                     end
                     KIND_SCALE: begin
                        current_valid_in = (b == LEN_SCALE);
                        if (b == LEN_SCALE) found_flags_in[FLAG_SCALE] = 1'b1;
                     end
                     KIND_STAMP: begin
                        current_valid_in = (b == LEN_STAMP);
                        if (b == LEN_STAMP) found_flags_in[FLAG_STAMP] = 1'b1;
                     end
                     KIND_SACK_OK: begin
                        if (b == LEN_SACK_OK) found_flags_in[FLAG_SACK_OK] = 1'b1;
                     end
                     KIND_SACK: begin
                        if (b > HDR_BYTES && len_minus_hdr[2:0] == 3'd0) begin
                           found_flags_in[FLAG_SACK] = 1'b1;
                           sack_count_store_in       = len_minus_hdr[5:3];
                           sack_offset_store_in      = pos_now + 6'd1;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end else begin
               if (valid_now) begin
                  case (current_kind_ff)
                     KIND_MSS: begin
                        if (data_index == 6'd0) begin
                           mss_store_in[15:8] = b;
                        end else begin
                           mss_store_in[7:0] = b;
                        end
                     end
                     KIND_SCALE: begin
                        scale_store_in = (b < SCALE_LIMIT) ? b[3:0] : SCALE_LIMIT[3:0];
                     end
                     KIND_STAMP: begin
                        if (data_index < 6'd4) begin
                           stamp_value_store_in = (stamp_value_store_ff
                              & ~(32'hFF << stamp_shift)) | ({24'd0, b} << stamp_shift);
                        end else begin
                           stamp_echo_store_in = (stamp_echo_store_ff
                              & ~(32'hFF << stamp_shift)) | ({24'd0, b} << stamp_shift);
                        end
                     end
                     default: begin
                     end
                  endcase
               end
               if ({2'd0, index_step} >= current_length_ff) begin
                  index_in_option_in = 6'd0;
               end else begin
                  index_in_option_in = index_step;
               end
            end
         end

         byte_position_in = pos_now + 6'd1;
         bytes_left_in    = left_now - 6'd1;
      end

      emit = active && (bytes_left_in == 6'd0);

      result.mss_present   = found_flags_in[FLAG_MSS];
      result.mss_value     = found_flags_in[FLAG_MSS] ? mss_store_in : 16'd0;
      result.scale_present = found_flags_in[FLAG_SCALE];
      result.scale_shift   = found_flags_in[FLAG_SCALE] ? scale_store_in : 4'd0;
      result.stamp_present = found_flags_in[FLAG_STAMP];
      result.stamp_value   = found_flags_in[FLAG_STAMP] ? stamp_value_store_in : 32'd0;
      result.stamp_echo    = found_flags_in[FLAG_STAMP] ? stamp_echo_store_in : 32'd0;
      result.sack_allowed  = found_flags_in[FLAG_SACK_OK];
      result.sack_present  = found_flags_in[FLAG_SACK];
      result.sack_blocks   = found_flags_in[FLAG_SACK] ? sack_count_store_in : 3'd0;
      result.sack_offset   = found_flags_in[FLAG_SACK] ? sack_offset_store_in : 6'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff        <= '0;
         byte_position_ff     <= '0;
         parse_stopped_ff     <= 1'b0;
         current_kind_ff      <= '0;
         current_length_ff    <= '0;
         index_in_option_ff   <= '0;
         current_valid_ff     <= 1'b0;
         found_flags_ff       <= '0;
         mss_store_ff         <= '0;
         scale_store_ff       <= '0;
         stamp_value_store_ff <= '0;
         stamp_echo_store_ff  <= '0;
         sack_count_store_ff  <= '0;
         sack_offset_store_ff <= '0;
      end else if (enable) begin
         bytes_left_ff        <= bytes_left_in;
         byte_position_ff     <= byte_position_in;
         parse_stopped_ff     <= parse_stopped_in;
         current_kind_ff      <= current_kind_in;
         current_length_ff    <= current_length_in;
         index_in_option_ff   <= index_in_option_in;
         current_valid_ff     <= current_valid_in;
         found_flags_ff       <= found_flags_in;
         mss_store_ff         <= mss_store_in;
         scale_store_ff       <= scale_store_in;
         stamp_value_store_ff <= stamp_value_store_in;
         stamp_echo_store_ff  <= stamp_echo_store_in;
         sack_count_store_ff  <= sack_count_store_in;
         sack_offset_store_ff <= sack_offset_store_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/tcp_option_parser.sv =====
// Top level of the TCP option parser: request handshake and registered result stage.
//
// The parser takes one option-area byte per cycle while req_ready is high and produces
// one record when the last byte of an area is taken. The parse state advances in a
// single pass of logic per byte, and the record lands in a result register in the cycle
// after the area's last byte is accepted. A new byte is accepted while a finished record
// waits, as long as that record is taken in the same cycle or the result register is
// empty. Areas longer than MAX_AREA_BYTES are cut to that length.
`default_nettype none

module tcp_option_parser
   import tcpop_pkg::*;
#(
   parameter int MAX_AREA_BYTES = MAX_AREA_BYTES_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;
   logic    accept;
   logic    emit;
   rsp_type result;

   tcpop_parse #(
      .MAX_AREA_BYTES(MAX_AREA_BYTES)
   ) u_parse (
      .clock  (clock),
      .reset  (reset),
      .enable (accept),
      .req    (req_data),
      .emit   (emit),
      .result (result)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      if (accept) begin
         rsp_valid_in = emit;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_data_ff <= result;
      end
   end

endmodule

`default_nettype wire

// ===== tb/tb_tcp_option_parser.sv =====
// Self-checking testbench for the TCP option parser, with a built-in record predictor.
`default_nettype none

module tb_tcp_option_parser;
   timeunit 1ns;
   timeprecision 1ps;

   import tcpop_pkg::*;

   localparam int SACK_BLOCK_BYTES = 8;
   localparam int AREA_LIMIT = MAX_AREA_BYTES_DEFAULT;
   localparam int ITEM_TARGET = 1650;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 8;

   class option_record_checker;
      rsp_type    expected_records[$];
      int         failures;
      logic [5:0] remain, pos, opt_index;
      logic       halted, kind_ok;
      logic [7:0] kind, opt_len;
      logic [4:0] seen;
      logic [15:0] mss;
      logic [3:0] shift;
      logic [31:0] tsval, tsecr;
      logic [2:0] sack_count;
      logic [5:0] sack_start;

      function new();
         failures = 0;
         remain = '0;
         pos = '0;
         opt_index = '0;
         halted = 1'b0;
         kind_ok = 1'b0;
         kind = '0;
         opt_len = '0;
         seen = '0;
         mss = '0;
         shift = '0;
         tsval = '0;
         tsecr = '0;
         sack_count = '0;
         sack_start = '0;
      endfunction

      function int pending();
         return expected_records.size();
      endfunction

      function void parse_length(logic [7:0] b);
         if (int'(b) < int'(HDR_BYTES) || int'(b) > int'(remain) + 1) begin
            halted = 1'b1;
            return;
         end
         opt_len = b;
         kind_ok = 1'b0;
         case (kind)
            KIND_MSS: begin
               kind_ok = (b == LEN_MSS);
               if (kind_ok) seen[FLAG_MSS] = 1'b1;
            end
            KIND_SCALE: begin
               kind_ok = (b == LEN_SCALE);
               if (kind_ok) seen[FLAG_SCALE] = 1'b1;
            end
            KIND_STAMP: begin
               kind_ok = (b == LEN_STAMP);
               if (kind_ok) seen[FLAG_STAMP] = 1'b1;
            end
            KIND_SACK_OK: begin
               if (b == LEN_SACK_OK) seen[FLAG_SACK_OK] = 1'b1;
            end
            KIND_SACK: begin
               if (b > HDR_BYTES && (int'(b) - int'(HDR_BYTES)) % SACK_BLOCK_BYTES == 0) begin
                  seen[FLAG_SACK] = 1'b1;
                  sack_count = 3'((int'(b) - int'(HDR_BYTES)) / SACK_BLOCK_BYTES);
                  sack_start = pos + 6'd1;
               end
            end
            default: ;
         endcase
         opt_index = (b == HDR_BYTES) ? 6'd0 : 6'd2;
      endfunction

      function void parse_data(logic [7:0] b);
         int d;
         d = int'(opt_index) - int'(HDR_BYTES);
         if (kind_ok) begin
            if (kind == KIND_MSS) begin
               if (d == 0) mss[15:8] = b;
               else mss[7:0] = b;
            end else if (kind == KIND_SCALE) begin
               shift = (b < SCALE_LIMIT) ? b[3:0] : SCALE_LIMIT[3:0];
            end else if (kind == KIND_STAMP) begin
               if (d < 4) tsval[(3 - (d % 4)) * 8 +: 8] = b;
               else tsecr[(3 - (d % 4)) * 8 +: 8] = b;
            end
         end
         opt_index = opt_index + 6'd1;
         if (int'(opt_index) >= int'(opt_len)) opt_index = '0;
      endfunction

      function void take_option_byte(req_type r);
         int len;
         rsp_type rec;
         len = int'(r.area_length);
         if (r.area_start) begin
            if (len == 0) len = 1;
            if (len > AREA_LIMIT) len = AREA_LIMIT;
            remain = 6'(len);
            pos = '0;
            halted = 1'b0;
            opt_index = '0;
            kind_ok = 1'b0;
            seen = '0;
         end else if (remain == 0) begin
            return;
         end
         if (!halted) begin
            if (opt_index == 0) begin
               if (r.option_byte == KIND_EOL) begin
                  halted = 1'b1;
               end else if (r.option_byte != KIND_NOP) begin
                  if (int'(remain) < int'(HDR_BYTES)) begin
                     halted = 1'b1;
                  end else begin
                     kind = r.option_byte;
                     opt_index = 6'd1;
                  end
               end
            end else if (opt_index == 1) begin
               parse_length(r.option_byte);
            end else begin
               parse_data(r.option_byte);
            end
         end
         pos = pos + 6'd1;
         remain = remain - 6'd1;
         if (remain != 0) return;
         rec = '0;
         rec.mss_present = seen[FLAG_MSS];
         rec.mss_value = seen[FLAG_MSS] ? mss : '0;
         rec.scale_present = seen[FLAG_SCALE];
         rec.scale_shift = seen[FLAG_SCALE] ? shift : '0;
         rec.stamp_present = seen[FLAG_STAMP];
         rec.stamp_value = seen[FLAG_STAMP] ? tsval : '0;
         rec.stamp_echo = seen[FLAG_STAMP] ? tsecr : '0;
         rec.sack_allowed = seen[FLAG_SACK_OK];
         rec.sack_present = seen[FLAG_SACK];
         rec.sack_blocks = seen[FLAG_SACK] ? sack_count : '0;
         rec.sack_offset = seen[FLAG_SACK] ? sack_start : '0;
         expected_records.push_back(rec);
      endfunction

      function bit field_differs(string name, logic [31:0] want, logic [31:0] got);
         if (got === want) return 1'b0;
         if (failures < 10)
            $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, name, want, got);
         return 1'b1;
      endfunction

      function void check_record(rsp_type got);
         rsp_type want;
         bit bad;
         if (expected_records.size() == 0) begin
            if (failures < 10)
               $display("%0t: unexpected record %h", $realtime, got);
            failures++;
            return;
         end
         want = expected_records.pop_front();
         bad = 1'b0;
         bad |= field_differs("mss_present", 32'(want.mss_present), 32'(got.mss_present));
         bad |= field_differs("mss_value", 32'(want.mss_value), 32'(got.mss_value));
         bad |= field_differs("scale_present", 32'(want.scale_present), 32'(got.scale_present));
         bad |= field_differs("scale_shift", 32'(want.scale_shift), 32'(got.scale_shift));
         bad |= field_differs("stamp_present", 32'(want.stamp_present), 32'(got.stamp_present));
         bad |= field_differs("stamp_value", want.stamp_value, got.stamp_value);
         bad |= field_differs("stamp_echo", want.stamp_echo, got.stamp_echo);
         bad |= field_differs("sack_allowed", 32'(want.sack_allowed), 32'(got.sack_allowed));
         bad |= field_differs("sack_present", 32'(want.sack_present), 32'(got.sack_present));
         bad |= field_differs("sack_blocks", 32'(want.sack_blocks), 32'(got.sack_blocks));
         bad |= field_differs("sack_offset", 32'(want.sack_offset), 32'(got.sack_offset));
         if (bad) failures++;
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   option_record_checker records;
   logic [7:0] area_bytes[$];
   int sender_idle = 0;
   int receiver_stall = 0;
   int items_sent = 0;
   int quiet_cycles = 0;

   tcp_option_parser u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   initial rsp_ready = 1'b0;
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= receiver_stall);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) records.take_option_byte(req_data);
         if (rsp_valid && rsp_ready) records.check_record(rsp_data);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   task automatic send_item(input req_type r);
      while ($urandom_range(0, 99) < sender_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_area(input int field, input int count);
      req_type r;
      for (int i = 0; i < count; i++) begin
         r.option_byte = area_bytes[i];
         r.area_start = (i == 0);
         r.area_length = (i == 0) ? 6'(field) : 6'($urandom);
         send_item(r);
      end
   endtask

   task automatic wait_for_records();
      req_valid <= 1'b0;
      @(posedge clock);
      while (records.pending() != 0) @(posedge clock);
   endtask

   function automatic void compose_area(input int target, input bit noise);
      logic [7:0] opt[$];
      logic [7:0] k;
      int pick;
      int n;
      area_bytes.delete();
      while (area_bytes.size() < target) begin
         opt.delete();
         pick = noise ? 100 : $urandom_range(0, 99);
         if (pick < 12) begin
            opt.push_back(KIND_NOP);
         end else if (pick < 24) begin
            opt = '{KIND_MSS, LEN_MSS, 8'($urandom), 8'($urandom)};
         end else if (pick < 36) begin
            k = $urandom_range(0, 1) ? 8'($urandom_range(0, 20)) : 8'($urandom);
            opt = '{KIND_SCALE, LEN_SCALE, k};
         end else if (pick < 46) begin
            opt = '{KIND_SACK_OK, LEN_SACK_OK};
         end else if (pick < 58) begin
            n = $urandom_range(1, 4);
            opt = '{KIND_SACK, 8'(int'(HDR_BYTES) + SACK_BLOCK_BYTES * n)};
            repeat (SACK_BLOCK_BYTES * n) opt.push_back(8'($urandom));
         end else if (pick < 72) begin
            opt = '{KIND_STAMP, LEN_STAMP};
            repeat (8) opt.push_back(8'($urandom));
         end else if (pick < 86) begin
            if (pick < 78) begin
               k = 8'($urandom_range(6, 255));
               if (k == KIND_STAMP) k = 8'd9;
            end else begin
               case ($urandom_range(0, 4))
                  0: k = KIND_MSS;
                  1: k = KIND_SCALE;
                  2: k = KIND_SACK_OK;
                  3: k = KIND_SACK;
                  default: k = KIND_STAMP;
               endcase
            end
            n = $urandom_range(2, 12);
            opt = '{k, 8'(n)};
            repeat (n - 2) opt.push_back(8'($urandom));
         end else if (pick < 90) begin
            opt = '{8'($urandom_range(2, 255)), 8'($urandom_range(0, 1))};
         end else if (pick < 93) begin
            opt.push_back(KIND_EOL);
         end else begin
            opt.push_back(8'($urandom));
         end
         for (int i = 0; i < opt.size() && area_bytes.size() < target; i++)
            area_bytes.push_back(opt[i]);
      end
   endfunction

   task automatic run_random_area();
      int sel;
      int target;
      int field;
      int count;
      sel = $urandom_range(0, 99);
      if (sel < 4) begin
         field = 0;
         target = 1;
      end else if (sel < 9) begin
         field = $urandom_range(AREA_LIMIT + 1, 63);
         target = AREA_LIMIT;
      end else if (sel < 55) begin
         target = $urandom_range(1, 16);
         field = target;
      end else begin
         target = $urandom_range(17, AREA_LIMIT);
         field = target;
      end
      compose_area(target, $urandom_range(0, 99) < 15);
      count = target;
      if (target > 1 && $urandom_range(0, 99) < 6) count = $urandom_range(1, target - 1);
      if (field > AREA_LIMIT) begin
         repeat ($urandom_range(0, 3)) area_bytes.push_back(8'($urandom));
         count = area_bytes.size();
      end
      send_area(field, count);
      items_sent += count;
   endtask

   initial begin
      req_type r;
      records = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      r.option_byte = 8'hA5;
      r.area_start = 1'b0;
      r.area_length = 6'h3F;
      send_item(r);
      area_bytes = '{8'hFF};
      send_area(0, 1);
      area_bytes = '{KIND_MSS, LEN_MSS, 8'hFF, 8'hFF, KIND_SCALE, LEN_SCALE, 8'hFF, KIND_EOL};
      send_area(8, 8);
      area_bytes = '{KIND_NOP, KIND_NOP};
      send_area(10, 2);
      area_bytes = '{KIND_SACK_OK, LEN_SACK_OK, KIND_STAMP, LEN_STAMP, 8'h80, 8'h00,
                     8'h00, 8'h01, 8'hFF, 8'hFE, 8'hFD, 8'hFC};
      send_area(12, 12);
      wait_for_records();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_idle = 0;  receiver_stall = 0;  end
            1: begin sender_idle = 63; receiver_stall = 0;  end
            2: begin sender_idle = 0;  receiver_stall = 63; end
            default: begin sender_idle = 14; receiver_stall = 14; end
         endcase
         while (items_sent < (phase + 1) * ITEM_TARGET / 4) run_random_area();
         wait_for_records();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (records.failures == 0 && records.pending() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
hw/rtl/tcpop_pkg.sv
hw/rtl/tcpop_parse.sv
hw/rtl/tcp_option_parser.sv
tb/tb_tcp_option_parser.sv
